### sv/mmfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfb_pkg
// Shared types, constants and helpers for the Modbus motor frame builder.
// ----------------------------------------------------------------------------
package mmfb_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 8;
    localparam int SPEED_W = 16;
    localparam int DIST_W  = 31;
    localparam int POS_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int IDX_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_ADDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATE_ADDR = 1'd1;
    localparam logic [ADDR_W-1:0]    SLAVE_ADDR_RST = 8'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ROTATE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RAIL_ABS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PLATE_ABS = 3'd4;

    // Modbus function codes, register addresses and coil values
    localparam logic [BYTE_W-1:0] FC_WRITE_COIL  = 8'h05;
    localparam logic [BYTE_W-1:0] FC_WRITE_REG   = 8'h06;
    localparam logic [BYTE_W-1:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [BYTE_W-1:0] REG_BASE       = 8'h08;
    localparam logic [BYTE_W-1:0] REG_COUNT      = 8'h04;
    localparam logic [BYTE_W-1:0] BYTE_COUNT     = 8'h08;
    localparam logic [BYTE_W-1:0] COIL_STOP      = 8'h03;
    localparam logic [BYTE_W-1:0] COIL_FWD       = 8'h04;
    localparam logic [BYTE_W-1:0] COIL_REV       = 8'h05;
    localparam logic [BYTE_W-1:0] COIL_RUN       = 8'h07;
    localparam logic [BYTE_W-1:0] COIL_ON        = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;

    localparam logic [SPEED_W-1:0] RAIL_SPEED  = 16'd100;
    localparam logic [SPEED_W-1:0] PLATE_SPEED = 16'd1000;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [IDX_W-1:0] MOVE_BODY_LEN  = 5'd15;
    localparam logic [IDX_W-1:0] SHORT_BODY_LEN = 5'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEND
    } t_state;

    typedef enum logic [2:0] {
        FR_MOVE,   // multi-register move write
        FR_RUN,    // run coil
        FR_SPEED,  // single speed register write
        FR_FCOIL,  // forward / reverse coil
        FR_STOP    // stop coil
    } t_frame;

    // Controller to datapath
    typedef struct packed {
        logic              load;       // latch command fields
        logic              prep;       // resolve move parameters
        logic              emit;       // load one byte into output register
        t_frame            frame;
        logic [IDX_W-1:0]  idx;        // byte position in frame
        logic              frame_end;
        logic              last;
    } t_dp_ctl;

    function automatic logic [IDX_W-1:0] frame_len(input t_frame fr);
        return (fr == FR_MOVE) ? MOVE_BODY_LEN : SHORT_BODY_LEN;
    endfunction

    // Modbus CRC-16, one byte, bit-serial over eight steps
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/mmfb_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfb_cmd_if
// Command channel: one motor command per beat.
// ----------------------------------------------------------------------------
interface mmfb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [mmfb_pkg::CMD_W-1:0]          command;
    logic [mmfb_pkg::ADDR_W-1:0]         slave_address;
    logic                                direction;
    logic [mmfb_pkg::SPEED_W-1:0]        speed;
    logic [mmfb_pkg::DIST_W-1:0]         distance;
    logic signed [mmfb_pkg::POS_W-1:0]   target_position;

    modport source (
        output valid, command, slave_address, direction, speed, distance,
               target_position,
        input  ready
    );
    modport sink (
        input  valid, command, slave_address, direction, speed, distance,
               target_position,
        output ready
    );
endinterface

### sv/mmfb_tx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfb_tx_if
// Byte channel: one serial byte per beat with frame markers.
// ----------------------------------------------------------------------------
interface mmfb_tx_if;
    logic                          valid;
    logic                          ready;
    logic [mmfb_pkg::BYTE_W-1:0]   tx_byte;
    logic                          frame_end;
    logic                          last;

    modport source (
        output valid, tx_byte, frame_end, last,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, frame_end, last,
        output ready
    );
endinterface

### sv/mmfb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfb_dp
// Datapath: command latch, axis positions, byte mux, CRC and output register.
// ----------------------------------------------------------------------------
module mmfb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mmfb_pkg::t_dp_ctl                 i_ctl,
    output logic                              o_out_free,
    // command payload
    input  logic [mmfb_pkg::CMD_W-1:0]        i_command,
    input  logic [mmfb_pkg::ADDR_W-1:0]       i_slave_address,
    input  logic                              i_direction,
    input  logic [mmfb_pkg::SPEED_W-1:0]      i_speed,
    input  logic [mmfb_pkg::DIST_W-1:0]       i_distance,
    input  logic signed [mmfb_pkg::POS_W-1:0] i_target_position,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mmfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mmfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // byte output
    input  logic                              i_tx_ready,
    output logic                              o_tx_valid,
    output logic [mmfb_pkg::BYTE_W-1:0]       o_tx_byte,
    output logic                              o_frame_end,
    output logic                              o_last
);
    import mmfb_pkg::*;

    logic [ADDR_W-1:0]       r_rail_addr, r_plate_addr;
    logic signed [POS_W-1:0] r_rail_pos, r_plate_pos;

    // latched command
    logic [CMD_W-1:0]        r_cmd;
    logic [ADDR_W-1:0]       r_in_addr;
    logic                    r_fwd;
    logic [SPEED_W-1:0]      r_in_speed;
    logic [DIST_W-1:0]       r_in_dist;
    logic signed [POS_W-1:0] r_tgt;

    // resolved frame parameters
    logic [ADDR_W-1:0]       r_addr;
    logic [SPEED_W-1:0]      r_speed;
    logic [DIST_W-1:0]       r_dist;
    logic [BYTE_W-1:0]       r_dirb;

    logic [CRC_W-1:0]        r_crc;
    logic                    r_ovalid;
    logic [BYTE_W-1:0]       r_tx_byte;
    logic                    r_frame_end;
    logic                    r_last;

    logic signed [POS_W-1:0] sel_pos;
    logic [POS_W:0]          diff;
    logic [POS_W:0]          mag;
    logic                    neg;
    logic [BYTE_W-1:0]       body;
    logic [IDX_W-1:0]        len;
    logic [CRC_W-1:0]        crc_base;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail_addr  <= SLAVE_ADDR_RST;
            r_plate_addr <= SLAVE_ADDR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAIL_ADDR:  r_rail_addr  <= i_cfg_data;
                CFG_PLATE_ADDR: r_plate_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- command latch ----
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_command;
            r_in_addr  <= i_slave_address;
            r_fwd      <= i_direction;
            r_in_speed <= i_speed;
            r_in_dist  <= i_distance;
            r_tgt      <= i_target_position;
        end
    end

    // ---- absolute move difference ----
    assign sel_pos = (r_cmd == CMD_RAIL_ABS) ? r_rail_pos : r_plate_pos;
    assign diff    = {r_tgt[POS_W-1], r_tgt} - {sel_pos[POS_W-1], sel_pos};
    assign neg     = diff[POS_W];
    assign mag     = neg ? (~diff + 1'b1) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail_pos  <= '0;
            r_plate_pos <= '0;
        end else if (i_ctl.prep) begin
            if (r_cmd == CMD_RAIL_ABS)  r_rail_pos  <= r_tgt;
            if (r_cmd == CMD_PLATE_ABS) r_plate_pos <= r_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prep) begin
            priority if (r_cmd == CMD_RAIL_ABS) begin
                r_addr  <= r_rail_addr;
                r_speed <= RAIL_SPEED;
                r_dist  <= {{(DIST_W-POS_W){1'b0}}, mag[POS_W-1:0]};
                r_dirb  <= {7'd0, ~neg};
            end else if (r_cmd == CMD_PLATE_ABS) begin
                r_addr  <= r_plate_addr;
                r_speed <= PLATE_SPEED;
                r_dist  <= {{(DIST_W-POS_W){1'b0}}, mag[POS_W-1:0]};
                r_dirb  <= {7'd0, neg};
            end else begin
                r_addr  <= r_in_addr;
                r_speed <= r_in_speed;
                r_dist  <= r_in_dist;
                r_dirb  <= {7'd0, ~r_fwd};
            end
        end
    end

    // ---- frame body byte ----
    always_comb begin
        body = BYTE_ZERO;
        unique case (i_ctl.frame)
            FR_MOVE: begin
                unique case (i_ctl.idx)
                    5'd0:  body = r_addr;
                    5'd1:  body = FC_WRITE_MULTI;
                    5'd3:  body = REG_BASE;
                    5'd5:  body = REG_COUNT;
                    5'd6:  body = BYTE_COUNT;
                    5'd7:  body = r_speed[15:8];
                    5'd8:  body = r_speed[7:0];
                    5'd9:  body = r_dist[15:8];
                    5'd10: body = r_dist[7:0];
                    5'd11: body = {1'b0, r_dist[30:24]};
                    5'd12: body = r_dist[23:16];
                    5'd14: body = r_dirb;
                    default: body = BYTE_ZERO;
                endcase
            end
            FR_SPEED: begin
                unique case (i_ctl.idx)
                    5'd0:    body = r_addr;
                    5'd1:    body = FC_WRITE_REG;
                    5'd3:    body = REG_BASE;
                    5'd4:    body = r_speed[15:8];
                    5'd5:    body = r_speed[7:0];
                    default: body = BYTE_ZERO;
                endcase
            end
            FR_RUN, FR_FCOIL, FR_STOP: begin
                unique case (i_ctl.idx)
                    5'd0: body = r_addr;
                    5'd1: body = FC_WRITE_COIL;
                    5'd3: begin
                        unique case (i_ctl.frame)
                            FR_RUN:   body = COIL_RUN;
                            FR_STOP:  body = COIL_STOP;
                            default:  body = r_fwd ? COIL_FWD : COIL_REV;
                        endcase
                    end
                    5'd4:    body = COIL_ON;
                    default: body = BYTE_ZERO;
                endcase
            end
            default: body = BYTE_ZERO;
        endcase
    end

    assign len      = frame_len(i_ctl.frame);
    assign crc_base = (i_ctl.idx == '0) ? CRC_INIT : r_crc;

    // ---- output register ----
    assign o_out_free = !r_ovalid || i_tx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_crc    <= CRC_INIT;
        end else if (i_ctl.emit) begin
            r_ovalid <= 1'b1;
            if (i_ctl.idx < len) r_crc <= crc16_byte(crc_base, body);
        end else if (i_tx_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            priority if (i_ctl.idx < len) r_tx_byte <= body;
            else if (i_ctl.idx == len)    r_tx_byte <= r_crc[7:0];
            else                          r_tx_byte <= r_crc[15:8];
            r_frame_end <= i_ctl.frame_end;
            r_last      <= i_ctl.last;
        end
    end

    assign o_tx_valid  = r_ovalid;
    assign o_tx_byte   = r_tx_byte;
    assign o_frame_end = r_frame_end;
    assign o_last      = r_last;

endmodule

### sv/mmfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfb_ctrl
// Controller: accepts commands and walks frames byte by byte.
// ----------------------------------------------------------------------------
module mmfb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic [mmfb_pkg::CMD_W-1:0]    i_command,
    output logic                          o_cmd_ready,
    input  logic                          i_out_free,
    output mmfb_pkg::t_dp_ctl             o_ctl
);
    import mmfb_pkg::*;

    t_state           r_state, n_state;
    t_frame           r_frame, n_frame;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             has_next;
    t_frame           next_frame;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign has_next    = (r_frame == FR_MOVE) || (r_frame == FR_SPEED);
    assign next_frame  = (r_frame == FR_MOVE) ? FR_RUN : FR_FCOIL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_frame <= FR_STOP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_frame <= n_frame;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_frame         = r_frame;
        n_idx           = r_idx;
        o_ctl           = '0;
        o_ctl.frame     = r_frame;
        o_ctl.idx       = r_idx;
        o_ctl.load      = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_idx = '0;
                    priority if (i_command == CMD_MOVE || i_command == CMD_RAIL_ABS ||
                                 i_command == CMD_PLATE_ABS) begin
                        n_frame = FR_MOVE;
                        n_state = ST_PREP;
                    end else if (i_command == CMD_ROTATE) begin
                        n_frame = FR_SPEED;
                        n_state = ST_PREP;
                    end else if (i_command == CMD_STOP) begin
                        n_frame = FR_STOP;
                        n_state = ST_PREP;
                    end else begin
                        n_state = ST_IDLE;  // unknown code: dropped
                    end
                end
            end
            ST_PREP: begin
                o_ctl.prep = 1'b1;
                n_state    = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_free) begin
                    o_ctl.emit = 1'b1;
                    if (r_idx == frame_len(r_frame) + 5'd1) begin
                        o_ctl.frame_end = 1'b1;
                        n_idx           = '0;
                        if (has_next) begin
                            n_frame = next_frame;
                        end else begin
                            o_ctl.last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit |-> i_out_free)
        else $error("byte loaded into a full output register");

    a_last_is_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && o_ctl.last) |-> o_ctl.frame_end)
        else $error("last beat not on a frame end");

    a_valid_cmd_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_MOVE || i_command == CMD_ROTATE ||
                    i_command == CMD_STOP || i_command == CMD_RAIL_ABS ||
                    i_command == CMD_PLATE_ABS)) |=> (r_state == ST_PREP))
        else $error("accepted command did not start");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && o_ctl.last) |=> o_cmd_ready)
        else $error("not ready after final beat");
`endif

endmodule

### sv/modbus_motor_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_motor_frame_builder
// Turns one motor command into Modbus RTU frames, one byte per beat.
// ----------------------------------------------------------------------------
// Each command on i_cmd becomes one or two Modbus RTU frames on o_tx, each
// closed by a Modbus CRC-16 sent low byte first; frame_end marks the CRC high
// byte and last marks the final beat of the command. Move (0) and the rail (3)
// and plate (4) absolute moves send a 17-byte multi-register write and an
// 8-byte run coil (25 beats); free rotate (1) sends a speed write and a
// forward/reverse coil (16 beats); stop (2) sends one 8-byte coil frame.
// Codes 5 to 7 are taken and dropped. Absolute moves keep each axis's last
// target and send the magnitude of the change. A command is accepted, then
// its move parameters are resolved, then its bytes go out. The byte rate is
// set by the single CRC/byte unit, which loads one byte per cycle into the
// output register while the sink keeps taking bytes. The next command is
// taken while the final byte still waits in that register. Slave
// addresses for the absolute moves are written through i_cfg_* (index 0
// rail, 1 plate, both reset to 1); the user must write them only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modbus_motor_frame_builder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mmfb_cmd_if.sink                        i_cmd,
    mmfb_tx_if.source                       o_tx,
    input  logic                            i_cfg_we,
    input  logic [mmfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mmfb_pkg::*;

    t_dp_ctl ctl;
    logic    out_free;
    logic    cmd_ready;

    // sequencing: accept, prepare, then frames byte by byte
    mmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_command   (i_cmd.command),
        .o_cmd_ready (cmd_ready),
        .i_out_free  (out_free),
        .o_ctl       (ctl)
    );

    assign i_cmd.ready = cmd_ready;

    // positions, byte mux, CRC and the output register
    mmfb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_out_free        (out_free),
        .i_command         (i_cmd.command),
        .i_slave_address   (i_cmd.slave_address),
        .i_direction       (i_cmd.direction),
        .i_speed           (i_cmd.speed),
        .i_distance        (i_cmd.distance),
        .i_target_position (i_cmd.target_position),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_tx_ready        (o_tx.ready),
        .o_tx_valid        (o_tx.valid),
        .o_tx_byte         (o_tx.tx_byte),
        .o_frame_end       (o_tx.frame_end),
        .o_last            (o_tx.last)
    );

endmodule

### tb/sv/tb_modbus_motor_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_motor_frame_builder
// Self-checking bench for the Modbus RTU motor command framer.
// ----------------------------------------------------------------------------
// Commands go in on the command channel and the bench predicts every byte
// beat of the resulting frames (CRC-16 included), along with the frame_end
// and last markers, and it tracks the rail and plate positions and slave
// addresses itself. Each beat out of the block is matched in order against
// the oldest predicted beat. A short table of corner-case commands runs
// first, then random traffic under three slave address settings, with random
// gaps on both sides, a stretch with no gaps, a long sink stall, and a full
// drain in the middle of the traffic.
// ----------------------------------------------------------------------------
module tb_modbus_motor_frame_builder;

    import mmfb_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 18;   // chance per cycle that a side idles
    localparam int HOLD_CYCLES  = 400;  // long sink stall
    localparam int DRAIN_CYCLES = 40;   // wait after the last predicted beat
    localparam int STALL_LIMIT  = 4000; // cycles with no beat on either side
    localparam int MAX_REPORTS  = 10;

    // Codes the block takes and drops
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    // Direction byte at the end of a move frame
    localparam logic [BYTE_W-1:0] MOVE_DIR_FWD = 8'h00;
    localparam logic [BYTE_W-1:0] MOVE_DIR_REV = 8'h01;

    // Beats per command, used in the corner-case table
    localparam int BEATS_MOVE   = 25;
    localparam int BEATS_ROTATE = 16;
    localparam int BEATS_STOP   = 8;
    localparam int BEATS_NONE   = 0;
    localparam int NO_ADDR      = -1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  slave_address;
        logic               direction;
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  distance;
        logic [POS_W-1:0]   target_position;
    } motor_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              frame_end;
        logic              last;
    } tx_beat_t;

    // Corner-case row: the command, the beat count it must produce and the
    // address byte that opens its first frame (NO_ADDR where not listed).
    typedef struct {
        motor_cmd_t item;
        int         exp_beats;
        int         exp_addr;
    } corner_row_t;

    localparam int CORNER_ROWS = 20;

    // Absolute rows run right after reset, so both axis addresses are 1 and
    // the slave_address field must be ignored (0x77 there).
    corner_row_t corner_rows [CORNER_ROWS] = '{
        // stop coil at the address extremes
        '{'{CMD_STOP, 8'h00, 1'b0, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_STOP, 0},
        '{'{CMD_STOP, 8'hFF, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 24'hFFFFFF},
          BEATS_STOP, 255},
        // move by distance: zero, full scale, mixed pattern
        '{'{CMD_MOVE, 8'h01, 1'b1, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_MOVE, 1},
        '{'{CMD_MOVE, 8'hFF, 1'b0, 16'hFFFF, 31'h7FFFFFFF, 24'h000000},
          BEATS_MOVE, 255},
        '{'{CMD_MOVE, 8'h5A, 1'b1, 16'h1234, 31'h12345678, 24'h000000},
          BEATS_MOVE, 'h5A},
        // free rotate, both directions
        '{'{CMD_ROTATE, 8'h00, 1'b1, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_ROTATE, 0},
        '{'{CMD_ROTATE, 8'hFF, 1'b0, 16'hFFFF, 31'h00000000, 24'h000000},
          BEATS_ROTATE, 255},
        // rail: zero change, full positive, full-scale backward, zero again
        '{'{CMD_RAIL_ABS, 8'h77, 1'b0, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_MOVE, 1},
        '{'{CMD_RAIL_ABS, 8'h77, 1'b0, 16'h0000, 31'h00000000, 24'h7FFFFF},
          BEATS_MOVE, 1},
        '{'{CMD_RAIL_ABS, 8'h77, 1'b0, 16'h0000, 31'h00000000, 24'h800000},
          BEATS_MOVE, 1},
        '{'{CMD_RAIL_ABS, 8'h77, 1'b0, 16'h0000, 31'h00000000, 24'h800000},
          BEATS_MOVE, 1},
        // plate: negative full, full-scale forward, back toward zero
        '{'{CMD_PLATE_ABS, 8'h77, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 24'h800000},
          BEATS_MOVE, 1},
        '{'{CMD_PLATE_ABS, 8'h77, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 24'h7FFFFF},
          BEATS_MOVE, 1},
        '{'{CMD_PLATE_ABS, 8'h77, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 24'h000000},
          BEATS_MOVE, 1},
        // unknown codes are swallowed
        '{'{CMD_RSVD_LO, 8'h00, 1'b0, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_NONE, NO_ADDR},
        '{'{CMD_RSVD_MID, 8'h12, 1'b1, 16'h8000, 31'h40000000, 24'h400000},
          BEATS_NONE, NO_ADDR},
        '{'{CMD_RSVD_HI, 8'hFF, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 24'hFFFFFF},
          BEATS_NONE, NO_ADDR},
        // state must be untouched by the unknown codes
        '{'{CMD_STOP, 8'hA5, 1'b0, 16'h0000, 31'h00000000, 24'h000000},
          BEATS_STOP, 'hA5},
        '{'{CMD_RAIL_ABS, 8'h77, 1'b1, 16'h0000, 31'h00000000, 24'hFFFFFF},
          BEATS_MOVE, 1},
        '{'{CMD_PLATE_ABS, 8'h77, 1'b0, 16'h0000, 31'h00000000, 24'h000001},
          BEATS_MOVE, 1}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mmfb_cmd_if cmd_if ();
    mmfb_tx_if  tx_if ();

    modbus_motor_frame_builder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_tx       (tx_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror of the block's state
    logic [POS_W-1:0]  rail_pos;
    logic [POS_W-1:0]  plate_pos;
    logic [ADDR_W-1:0] rail_addr;
    logic [ADDR_W-1:0] plate_addr;

    logic [BYTE_W-1:0] frame_body [15];
    tx_beat_t          tx_beats_due [$];

    int faults       = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    bit idle_en      = 1'b1;

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------

    // Reflected CRC-16 fed one bit at a time, LSB first
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] b, input logic fend);
        tx_beat_t t;
        t.tx_byte   = b;
        t.frame_end = fend;
        t.last      = 1'b0;
        tx_beats_due.push_back(t);
    endfunction

    // Queue frame_body[0 .. len-1] then its CRC, low byte first
    function automatic void push_frame(input int len);
        logic [CRC_W-1:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < len; k++) begin
            crc = crc_update(crc, frame_body[k]);
            push_beat(frame_body[k], 1'b0);
        end
        push_beat(crc[7:0], 1'b0);
        push_beat(crc[15:8], 1'b1);
    endfunction

    function automatic void push_coil(input logic [BYTE_W-1:0] addr,
                                      input logic [BYTE_W-1:0] coil);
        frame_body[0] = addr;
        frame_body[1] = FC_WRITE_COIL;
        frame_body[2] = BYTE_ZERO;
        frame_body[3] = coil;
        frame_body[4] = COIL_ON;
        frame_body[5] = BYTE_ZERO;
        push_frame(int'(SHORT_BODY_LEN));
    endfunction

    // Multi-register move write followed by the run coil
    function automatic void push_move(input logic [BYTE_W-1:0] addr,
                                      input logic [SPEED_W-1:0] spd,
                                      input logic [31:0] steps,
                                      input logic [BYTE_W-1:0] dirb);
        frame_body[0]  = addr;
        frame_body[1]  = FC_WRITE_MULTI;
        frame_body[2]  = BYTE_ZERO;
        frame_body[3]  = REG_BASE;
        frame_body[4]  = BYTE_ZERO;
        frame_body[5]  = REG_COUNT;
        frame_body[6]  = BYTE_COUNT;
        frame_body[7]  = spd[15:8];
        frame_body[8]  = spd[7:0];
        frame_body[9]  = steps[15:8];  // low word first, each word big-endian
        frame_body[10] = steps[7:0];
        frame_body[11] = steps[31:24];
        frame_body[12] = steps[23:16];
        frame_body[13] = BYTE_ZERO;
        frame_body[14] = dirb;
        push_frame(int'(MOVE_BODY_LEN));
        push_coil(addr, COIL_RUN);
    endfunction

    // Magnitude of (target - stored) on a 24-bit signed axis
    function automatic logic [31:0] axis_delta(input logic [POS_W-1:0] tgt,
                                               input logic [POS_W-1:0] pos,
                                               output logic neg);
        int t;
        int p;
        int d;
        t   = {{(32 - POS_W){tgt[POS_W-1]}}, tgt};
        p   = {{(32 - POS_W){pos[POS_W-1]}}, pos};
        d   = t - p;
        neg = (d < 0);
        return neg ? -d : d;
    endfunction

    // Queue every beat one command produces; returns how many
    function automatic int build_tx_beats(input motor_cmd_t c);
        int          n0;
        tx_beat_t    tail;
        logic        neg;
        logic [31:0] mag;
        n0 = tx_beats_due.size();
        case (c.command)
            CMD_MOVE: begin
                push_move(c.slave_address, c.speed, {1'b0, c.distance},
                          c.direction ? MOVE_DIR_FWD : MOVE_DIR_REV);
            end
            CMD_ROTATE: begin
                frame_body[0] = c.slave_address;
                frame_body[1] = FC_WRITE_REG;
                frame_body[2] = BYTE_ZERO;
                frame_body[3] = REG_BASE;
                frame_body[4] = c.speed[15:8];
                frame_body[5] = c.speed[7:0];
                push_frame(int'(SHORT_BODY_LEN));
                push_coil(c.slave_address, c.direction ? COIL_FWD : COIL_REV);
            end
            CMD_STOP: begin
                push_coil(c.slave_address, COIL_STOP);
            end
            CMD_RAIL_ABS: begin
                // rail runs forward on a negative change
                mag      = axis_delta(c.target_position, rail_pos, neg);
                rail_pos = c.target_position;
                push_move(rail_addr, RAIL_SPEED, mag,
                          neg ? MOVE_DIR_FWD : MOVE_DIR_REV);
            end
            CMD_PLATE_ABS: begin
                // plate has the opposite sense
                mag       = axis_delta(c.target_position, plate_pos, neg);
                plate_pos = c.target_position;
                push_move(plate_addr, PLATE_SPEED, mag,
                          neg ? MOVE_DIR_REV : MOVE_DIR_FWD);
            end
            default: begin
            end
        endcase
        if (tx_beats_due.size() > n0) begin
            tail      = tx_beats_due.pop_back();
            tail.last = 1'b1;
            tx_beats_due.push_back(tail);
        end
        return tx_beats_due.size() - n0;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one command and wait for its beat. valid stays up on return so
    // the next command can follow back to back; gaps lower it.
    task automatic send_cmd(input motor_cmd_t c, output int n_beats);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.command         <= c.command;
        cmd_if.slave_address   <= c.slave_address;
        cmd_if.direction       <= c.direction;
        cmd_if.speed           <= c.speed;
        cmd_if.distance        <= c.distance;
        cmd_if.target_position <= c.target_position;
        do
            @(posedge i_clk);
        while (!cmd_if.ready);
        n_beats = build_tx_beats(c);
    endtask

    // Stop offering commands until every predicted beat is out, then give
    // the block time to finish anything that makes no beat.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (tx_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RAIL_ADDR:  rail_addr  = val;
            CFG_PLATE_ADDR: plate_addr = val;
            default: begin
            end
        endcase
    endtask

    function automatic motor_cmd_t rand_cmd();
        motor_cmd_t c;
        if ($urandom_range(99) < 6)
            c.command = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        else
            c.command = CMD_W'($urandom_range(CMD_PLATE_ABS, CMD_MOVE));
        c.slave_address = ADDR_W'($urandom);
        c.direction     = 1'($urandom);
        c.speed         = SPEED_W'($urandom);
        case ($urandom_range(3))
            0:       c.distance = DIST_W'($urandom_range(1000));
            1:       c.distance = $urandom_range(1) ? 31'h7FFFFFFF : 31'h0;
            default: c.distance = DIST_W'($urandom);
        endcase
        // Mix full-scale jumps and small steps around zero with random targets
        case ($urandom_range(3))
            0:       c.target_position = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            1:       c.target_position = 24'($urandom_range(64)) - 24'd32;
            default: c.target_position = POS_W'($urandom);
        endcase
        return c;
    endfunction

    // Random commands until n of them were ones the block acts on
    task automatic run_random(input int n);
        motor_cmd_t c;
        int         done;
        int         n_beats;
        done = 0;
        while (done < n) begin
            c = rand_cmd();
            send_cmd(c, n_beats);
            if (n_beats != 0)
                done++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte side: check each beat, then pick ready for the next cycle
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            tx_beat_t exp_beat;
            @(posedge i_clk);
            if (i_rst_n && tx_if.valid && tx_if.ready) begin
                if (tx_beats_due.size() == 0) begin
                    note_fault($sformatf("unexpected beat: byte %02h fend %0b last %0b",
                                         tx_if.tx_byte, tx_if.frame_end, tx_if.last));
                end else begin
                    exp_beat = tx_beats_due.pop_front();
                    if (tx_if.tx_byte !== exp_beat.tx_byte ||
                        tx_if.frame_end !== exp_beat.frame_end ||
                        tx_if.last !== exp_beat.last)
                        note_fault($sformatf({"beat mismatch: exp byte %02h fend %0b",
                                              " last %0b, got byte %02h fend %0b last %0b"},
                                             exp_beat.tx_byte, exp_beat.frame_end,
                                             exp_beat.last, tx_if.tx_byte,
                                             tx_if.frame_end, tx_if.last));
                end
            end
            // long stall on request so the block backs up into the command side
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end else begin
                tx_if.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: too long without a beat on either side ends the run
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (tx_if.valid && tx_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout after %0d cycles without a beat", STALL_LIMIT);
        $display("** modbus_motor_frame_builder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int n_beats;
        int first;

        cmd_if.valid           = 1'b0;
        cmd_if.command         = CMD_STOP;
        cmd_if.slave_address   = '0;
        cmd_if.direction       = 1'b0;
        cmd_if.speed           = '0;
        cmd_if.distance        = '0;
        cmd_if.target_position = '0;
        tx_if.ready            = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = CFG_RAIL_ADDR;
        cfg_data               = '0;

        rail_pos   = '0;
        plate_pos  = '0;
        rail_addr  = SLAVE_ADDR_RST;
        plate_addr = SLAVE_ADDR_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases with reset addresses; the listed count and opening
        // address must agree with what gets queued for the row.
        for (int r = 0; r < CORNER_ROWS; r++) begin
            send_cmd(corner_rows[r].item, n_beats);
            if (n_beats != corner_rows[r].exp_beats) begin
                note_fault($sformatf("row %0d: %0d beats queued, %0d listed",
                                     r, n_beats, corner_rows[r].exp_beats));
            end else if (corner_rows[r].exp_addr != NO_ADDR) begin
                first = tx_beats_due.size() - n_beats;
                if (tx_beats_due[first].tx_byte != 8'(corner_rows[r].exp_addr))
                    note_fault($sformatf("row %0d: address %02h queued, %02h listed",
                                         r, tx_beats_due[first].tx_byte,
                                         corner_rows[r].exp_addr));
            end
        end

        // Address extremes, one each way
        drain_results();
        cfg_write(CFG_RAIL_ADDR, 8'h00);
        cfg_write(CFG_PLATE_ADDR, 8'hFF);
        run_random(70);

        // Swapped extremes, no gaps on either side
        drain_results();
        cfg_write(CFG_RAIL_ADDR, 8'hFF);
        cfg_write(CFG_PLATE_ADDR, 8'h00);
        idle_en = 1'b0;
        run_random(60);
        idle_en = 1'b1;

        // Random addresses; long sink stall while commands keep coming, then
        // a full drain before the rest of the traffic.
        drain_results();
        cfg_write(CFG_RAIL_ADDR, CFG_DATA_W'($urandom));
        cfg_write(CFG_PLATE_ADDR, CFG_DATA_W'($urandom));
        hold_req = 1'b1;
        run_random(25);
        drain_results();
        run_random(55);

        drain_results();
        if (tx_beats_due.size() != 0)
            note_fault($sformatf("%0d beats never arrived", tx_beats_due.size()));

        if (faults == 0)
            $display("** modbus_motor_frame_builder: PASSED **");
        else
            $display("** modbus_motor_frame_builder: FAILED **");
        $finish;
    end

endmodule
